>>> hdl/pia_pkg.sv
// Shared types, constants and lookup functions for the pulse-injection aligner.
// Used by pia_core, pia_outbuf and bldc_pulse_injection_aligner; no dependencies.
package pia_pkg;

	// Default kept width of an ADC sample.
	localparam int SampleBitsDef = 12;
	// Width of the ADC sample port.
	localparam int AdcBits = 12;

	// Sequence positions with a special meaning.
	localparam logic [3:0] STAGE_DECIDE = 4'd12;
	localparam logic [3:0] STAGE_DONE   = 4'd13;
	localparam logic [3:0] STAGE_FIRST_PULSE = 4'd2;

	// Drive pattern with every switch off.
	localparam logic [2:0] ALL_OFF_LOW = 3'b111;

	// Position code bits, one per phase pair.
	localparam logic [2:0] CODE_U = 3'h4;
	localparam logic [2:0] CODE_V = 3'h2;
	localparam logic [2:0] CODE_W = 3'h1;

	// Register reset values.
	localparam logic [15:0] PULSE_COMPARE_RST = 16'd900;
	localparam logic [15:0] START_DUTY_RST    = 16'd200;

	typedef enum logic [1:0] {
		CMD_STEP    = 2'd0,
		CMD_SAMPLE  = 2'd1,
		CMD_CHARGE  = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_PULSE_COMPARE = 2'd0,
		REG_START_DUTY    = 2'd1
	} reg_idx_t;

	// One result item.
	typedef struct packed {
		logic        drive_update;
		logic [2:0]  low_off_mask;
		logic [2:0]  high_on_mask;
		logic [2:0]  pulse_index;
		logic        aligned;
		logic [2:0]  position_code;
		logic [2:0]  sector;
		logic [15:0] run_duty;
	} res_t;

	// High sides switched on for each injection pulse (bit2 U, bit1 V, bit0 W).
	function automatic logic [2:0] pulse_mask(input logic [2:0] pulse);
		logic [2:0] m;
		case (pulse)
			3'd0: m = 3'b110;
			3'd1: m = 3'b001;
			3'd2: m = 3'b101;
			3'd3: m = 3'b010;
			3'd4: m = 3'b011;
			3'd5: m = 3'b100;
			default: m = 3'b000;
		endcase
		return m;
	endfunction

	// Commutation sector for a position code; all-equal codes map to zero.
	function automatic logic [2:0] sector_of_code(input logic [2:0] code);
		logic [2:0] s;
		case (code)
			3'd1: s = 3'd2;
			3'd2: s = 3'd4;
			3'd3: s = 3'd3;
			3'd4: s = 3'd6;
			3'd5: s = 3'd1;
			3'd6: s = 3'd5;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

>>> hdl/pia_core.sv
// Sequencer state, sample store, configuration registers and result logic.
// Depends on pia_pkg.
module pia_core
	import pia_pkg::*;
#(
	parameter int SAMPLE_BITS = SampleBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic [1:0]           command,
	input  logic [AdcBits-1:0]   adc_sample,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	output res_t                 res
);

	localparam int KeepBits = (SAMPLE_BITS < AdcBits) ? SAMPLE_BITS : AdcBits;

	logic [3:0] stage_q, stage_d;
	logic       sample_busy_q, sample_busy_d;
	logic       charge_busy_q, charge_busy_d;
	logic [2:0] cur_pulse_q, cur_pulse_d;
	logic [2:0] code_q, code_d;
	logic       done_q, done_d;
	logic       upd;
	logic       smp_we;
	logic [2:0] decide;
	logic       show_pulse;
	logic [2:0] hi_mask;
	logic [SAMPLE_BITS-1:0] smp_in;
	logic [SAMPLE_BITS-1:0] samples_q [6];
	logic [15:0] pulse_compare_q;
	logic [15:0] start_duty_q;
	cmd_t        cmd;

	assign cmd    = cmd_t'(command);
	assign smp_in = SAMPLE_BITS'(adc_sample[KeepBits-1:0]);

	// Compare the pulse pairs into a position code
	always_comb begin
		decide = 3'b000;
		if (samples_q[0] <= samples_q[1]) decide = decide | CODE_U;
		if (samples_q[2] <= samples_q[3]) decide = decide | CODE_V;
		if (samples_q[4] <= samples_q[5]) decide = decide | CODE_W;
	end

	// Next sequencer state for an accepted request
	always_comb begin
		stage_d       = stage_q;
		sample_busy_d = sample_busy_q;
		charge_busy_d = charge_busy_q;
		cur_pulse_d   = cur_pulse_q;
		code_d        = code_q;
		done_d        = done_q;
		upd           = 1'b0;
		smp_we        = 1'b0;
		if (acc) begin
			case (cmd)
				CMD_STEP: begin
					if (!sample_busy_q && !charge_busy_q && stage_q < STAGE_DONE) begin
						upd = 1'b1;
						if (stage_q == STAGE_DECIDE) begin
							code_d  = code_q | decide;
							done_d  = 1'b1;
							stage_d = STAGE_DONE;
						end else begin
							if (!stage_q[0]) begin
								charge_busy_d = 1'b1;
							end else begin
								cur_pulse_d   = stage_q[3:1];
								sample_busy_d = 1'b1;
							end
							stage_d = stage_q + 4'd1;
						end
					end
				end
				CMD_SAMPLE: begin
					if (sample_busy_q) begin
						smp_we        = 1'b1;
						sample_busy_d = 1'b0;
					end
				end
				CMD_CHARGE: begin
					charge_busy_d = 1'b0;
				end
				CMD_RESTART: begin
					stage_d       = '0;
					sample_busy_d = 1'b0;
					charge_busy_d = 1'b0;
					cur_pulse_d   = '0;
					code_d        = '0;
					done_d        = 1'b0;
					upd           = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Drive pattern in force after the request: a pulse runs until the next charge
	assign show_pulse = (stage_d >= STAGE_FIRST_PULSE) && (stage_d <= STAGE_DECIDE)
		&& !stage_d[0];
	assign hi_mask = show_pulse ? pulse_mask(cur_pulse_d) : 3'b000;

	always_comb begin
		res.drive_update  = upd;
		res.low_off_mask  = show_pulse ? hi_mask : ALL_OFF_LOW;
		res.high_on_mask  = hi_mask;
		res.pulse_index   = cur_pulse_d;
		res.aligned       = done_d;
		res.position_code = done_d ? code_d : 3'b000;
		res.sector        = done_d ? sector_of_code(code_d) : 3'b000;
		res.run_duty      = done_d ? start_duty_q : 16'd0;
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q       <= '0;
			sample_busy_q <= 1'b0;
			charge_busy_q <= 1'b0;
			cur_pulse_q   <= '0;
			code_q        <= '0;
			done_q        <= 1'b0;
		end else begin
			stage_q       <= stage_d;
			sample_busy_q <= sample_busy_d;
			charge_busy_q <= charge_busy_d;
			cur_pulse_q   <= cur_pulse_d;
			code_q        <= code_d;
			done_q        <= done_d;
		end
	end

	// Store the sample of the pending pulse
	always_ff @(posedge clk) begin
		if (smp_we) begin
			samples_q[cur_pulse_q] <= smp_in;
		end
	end

	// Configuration registers; pulse_compare is stored but drives no output here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_compare_q <= PULSE_COMPARE_RST;
			start_duty_q    <= START_DUTY_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PULSE_COMPARE: pulse_compare_q <= cfg_data;
				REG_START_DUTY:    start_duty_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	a_one_wait: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample_busy_q && charge_busy_q))
		else $error("charge and sample pending at once");

	a_done_stage: assert property (@(posedge clk) disable iff (!arst_n)
		done_q == (stage_q == STAGE_DONE))
		else $error("done flag out of step with sequence position");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd == CMD_RESTART) |=> (stage_q == '0 && !done_q && code_q == '0))
		else $error("restart did not clear the run");

endmodule

>>> hdl/pia_outbuf.sv
// Two-entry result buffer between the sequencer and the output channel.
// Depends on pia_pkg.
module pia_outbuf
	import pia_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t din,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t dout
);

	res_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && !out_stall;
	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign dout      = ent_q[rd_q];

	// Hold results in order
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= din;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("result buffer count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("request pushed into full result buffer");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) == (wr_q != rd_q))
		else $error("result buffer pointers disagree with count");

endmodule

>>> hdl/bldc_pulse_injection_aligner.sv
// Top level of the pulse-injection rotor aligner for sensorless BLDC start-up.
// Depends on pia_pkg, pia_core and pia_outbuf.
//
// Usage:
//   Input channel (in_valid/in_stall, command, adc_sample) carries one event per
//   request: step, sample done, charge done or restart. Every accepted request
//   yields exactly one result on the output channel (out_valid/out_stall) with
//   the drive pattern in force, the last pulse index and, once aligned, the
//   position code, sector and run duty.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
//   taken; index 0 is pulse_compare, index 1 start_duty, others are ignored.
// Output: each result is registered in the output buffer and presented in order.
// Throughput: one request per cycle while in_stall is low; the sequencer
//   updates in the accepting cycle; results land in a two-entry output buffer.
// Reset: the sequence returns to charge-before-first-pulse, busy flags, code and
//   aligned flag clear, registers take 900 and 200, the buffer empties.
// Stall: the buffer keeps up to two results while out_stall is high; in_stall
//   rises only when both entries are occupied.
module bldc_pulse_injection_aligner
	import pia_pkg::*;
#(
	parameter int SAMPLE_BITS = SampleBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [AdcBits-1:0] adc_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               drive_update,
	output logic [2:0]         low_off_mask,
	output logic [2:0]         high_on_mask,
	output logic [2:0]         pulse_index,
	output logic               aligned,
	output logic [2:0]         position_code,
	output logic [2:0]         sector,
	output logic [15:0]        run_duty,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic acc;
	logic full;
	res_t res;
	res_t head;

	assign in_stall  = full;
	assign acc       = in_valid && !full;
	assign cfg_ready = 1'b1;

	pia_core #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.command    (command),
		.adc_sample (adc_sample),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res        (res)
	);

	pia_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.din       (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (head)
	);

	// Unpack the result at the head of the buffer
	assign drive_update  = head.drive_update;
	assign low_off_mask  = head.low_off_mask;
	assign high_on_mask  = head.high_on_mask;
	assign pulse_index   = head.pulse_index;
	assign aligned       = head.aligned;
	assign position_code = head.position_code;
	assign sector        = head.sector;
	assign run_duty      = head.run_duty;

endmodule
